[rtl/vaf_pkg.sv]
// ----------------------------------------------------------------------------
// vaf_pkg: shared types and constants for the view angle / field of view block
// Holds the sideband record that travels down the pipeline, the angle
// constants in 1/64 degree units and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package vaf_pkg;

  // Angles in 1/64 degree
  localparam int DEG64_HALF    = 11520;
  localparam int DEG64_QUARTER = 5760;
  localparam int DEG64_FULL    = 23040;

  // Fractional bits of the angle accumulator below 1/64 degree
  localparam int ANG_FRAC = 16;
  localparam int ZW       = 32;

  // Normalized magnitudes reach at least this bit
  localparam int NORM_BIT   = 40;
  localparam int NORM_STEPS = 6;

  localparam int ATAN_DEPTH = 24;

  // round(atan(2^-i) * 2^22 degrees)
  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'd188743680, 32'd111421900, 32'd58872272, 32'd29884485,
    32'd15000234,  32'd7507429,   32'd3754631,  32'd1877430,
    32'd938729,    32'd469366,    32'd234683,   32'd117342,
    32'd58671,     32'd29335,     32'd14668,    32'd7334,
    32'd3667,      32'd1833,      32'd917,      32'd458,
    32'd229,       32'd115,       32'd57,       32'd29
  };

  // Control and view data that ride along with each item
  typedef struct packed {
    logic               vld;
    logic               spec;      // aim taken from spec_aim, CORDIC result ignored
    logic               flip;      // vector was in the left half plane
    logic               ypos;      // dy > 0
    logic               yneg;      // start CORDIC with negative y
    logic signed [14:0] spec_aim;
    logic signed [14:0] yaw;
    logic signed [13:0] pitch;
  } sideband_t;

endpackage

`default_nettype wire

[rtl/vaf_norm_step.sv]
// ----------------------------------------------------------------------------
// vaf_norm_step: one registered step of the magnitude normalizer
// Shifts both magnitudes left by K when that keeps them at or below
// the normalization bit.
// ----------------------------------------------------------------------------
`default_nettype none

module vaf_norm_step #(
  parameter int W = 41,
  parameter int K = 1
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire  [W-1:0]           a_in,
  input  wire  [W-1:0]           b_in,
  input  vaf_pkg::sideband_t     sb_in,
  output logic [W-1:0]           a_out,
  output logic [W-1:0]           b_out,
  output vaf_pkg::sideband_t     sb_out
);

  logic [W-1:0]       a_r, a_nxt;
  logic [W-1:0]       b_r, b_nxt;
  vaf_pkg::sideband_t sb_r;
  logic               room;

  always_comb begin
    room = (((a_in | b_in) >> (vaf_pkg::NORM_BIT + 1 - K)) == '0);
    if (room) begin
      a_nxt = W'(a_in << K);
      b_nxt = W'(b_in << K);
    end else begin
      a_nxt = a_in;
      b_nxt = b_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r.vld <= 1'b0;
    end else begin
      sb_r <= sb_in;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign a_out  = a_r;
  assign b_out  = b_r;
  assign sb_out = sb_r;

endmodule

`default_nettype wire

[rtl/vaf_cordic_stage.sv]
// ----------------------------------------------------------------------------
// vaf_cordic_stage: one registered CORDIC vectoring micro-rotation
// Rotates toward y = 0 by atan(2^-I) and accumulates the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module vaf_cordic_stage #(
  parameter int XW = 44,
  parameter int I  = 0
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  signed [XW-1:0]          x_in,
  input  wire  signed [XW-1:0]          y_in,
  input  wire  signed [vaf_pkg::ZW-1:0] z_in,
  input  vaf_pkg::sideband_t            sb_in,
  output logic signed [XW-1:0]          x_out,
  output logic signed [XW-1:0]          y_out,
  output logic signed [vaf_pkg::ZW-1:0] z_out,
  output vaf_pkg::sideband_t            sb_out
);

  localparam logic signed [vaf_pkg::ZW-1:0] ATAN_I = $signed(vaf_pkg::ATAN_TAB[I]);

  logic signed [XW-1:0]          xs, ys;
  logic signed [XW-1:0]          x_r, x_nxt, y_r, y_nxt;
  logic signed [vaf_pkg::ZW-1:0] z_r, z_nxt;
  vaf_pkg::sideband_t            sb_r;

  always_comb begin
    xs = x_in >>> I;
    ys = y_in >>> I;
    if (!y_in[XW-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ATAN_I;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ATAN_I;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r.vld <= 1'b0;
    end else begin
      sb_r <= sb_in;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x_out  = x_r;
  assign y_out  = y_r;
  assign z_out  = z_r;
  assign sb_out = sb_r;

endmodule

`default_nettype wire

[rtl/vaf_fov_calc.sv]
// ----------------------------------------------------------------------------
// vaf_fov_calc: angle rounding, wrap and field of view selection
// Two register stages: round and wrap the aim yaw, then form the yaw and
// pitch differences and keep the larger.
// ----------------------------------------------------------------------------
`default_nettype none

module vaf_fov_calc (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  signed [vaf_pkg::ZW-1:0] z_in,
  input  vaf_pkg::sideband_t            sb_in,
  output logic                          out_valid,
  output logic signed [14:0]            out_aim_yaw,
  output logic        [14:0]            out_fov_angle
);

  localparam logic signed [17:0] HALF18    = 18'(vaf_pkg::DEG64_HALF);
  localparam logic signed [17:0] QUARTER18 = 18'(vaf_pkg::DEG64_QUARTER);
  localparam logic signed [17:0] FULL18    = 18'(vaf_pkg::DEG64_FULL);
  localparam logic signed [vaf_pkg::ZW:0] RND =
    (vaf_pkg::ZW+1)'(1) <<< (vaf_pkg::ANG_FRAC - 1);

  // Round and wrap
  logic signed [vaf_pkg::ZW:0] zr;
  logic signed [17:0]          a_raw, a_wrap;
  logic signed [14:0]          aim_r, aim_nxt;
  logic signed [14:0]          yaw_r;
  logic signed [13:0]          pitch_r;
  logic                        vld_r;

  always_comb begin
    zr    = $signed({z_in[vaf_pkg::ZW-1], z_in}) + RND;
    a_raw = 18'(zr >>> vaf_pkg::ANG_FRAC);
    if (a_raw > HALF18) begin
      a_wrap = a_raw - FULL18;
    end else if (a_raw < -HALF18) begin
      a_wrap = a_raw + FULL18;
    end else begin
      a_wrap = a_raw;
    end
    aim_nxt = sb_in.spec ? sb_in.spec_aim : a_wrap[14:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= sb_in.vld;
    end
    aim_r   <= aim_nxt;
    yaw_r   <= sb_in.yaw;
    pitch_r <= sb_in.pitch;
  end

  // Differences and maximum
  logic signed [17:0] yaw18, aim18, pit18, dyaw, dpit, fov;
  logic               valid_r;
  logic signed [14:0] aim_out_r;
  logic        [14:0] fov_r;

  always_comb begin
    yaw18 = 18'(yaw_r);
    aim18 = 18'(aim_r);
    pit18 = 18'(pitch_r);
    if (yaw18 < -QUARTER18 && aim18 > QUARTER18) begin
      dyaw = yaw18 + FULL18 - aim18;
    end else if (yaw18 > QUARTER18 && aim18 < -QUARTER18) begin
      dyaw = aim18 + FULL18 - yaw18;
    end else if (yaw18 > aim18) begin
      dyaw = yaw18 - aim18;
    end else begin
      dyaw = aim18 - yaw18;
    end
    if (dyaw < 0) begin
      dyaw = '0;
    end
    dpit = pit18[17] ? -pit18 : pit18;
    fov  = (dyaw > dpit) ? dyaw : dpit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vld_r;
    end
    aim_out_r <= aim_r;
    fov_r     <= fov[14:0];
  end

  assign out_valid     = valid_r;
  assign out_aim_yaw   = aim_out_r;
  assign out_fov_angle = fov_r;

endmodule

`default_nettype wire

[rtl/view_angle_fov_to_target.sv]
// ----------------------------------------------------------------------------
// view_angle_fov_to_target: aim yaw and field of view angle toward a target
// Each command carries the view pitch and yaw (1/64 degree) and the planar
// eye and target positions (signed Q16.16). The block returns the yaw
// toward the target, atan2(dy, dx) by CORDIC vectoring, and the larger of
// the yaw difference (with pole wrap) and the absolute pitch.
//
// Command channel: a transfer happens on a clock edge with start high and
// busy low. busy is held low: a new command is taken on every cycle.
// Result channel: out_valid is high for one cycle per command, with
// out_aim_yaw and out_fov_angle; the receiver must take it in that cycle.
// The pipeline holds the offset stage, the classify stage, six normalizer
// steps, the CORDIC setup stage, one stage per micro-rotation and two output
// stages.
// Throughput: one command per cycle, results in command order.
// Reset (synchronous, rst_n low) clears the valid bits of every stage;
// commands in flight are dropped and no result appears for them.
// ----------------------------------------------------------------------------
`default_nettype none

module view_angle_fov_to_target #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_BITS    = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire  signed [13:0]          in_view_pitch,
  input  wire  signed [14:0]          in_view_yaw,
  input  wire  signed [COORD_BITS-1:0] in_eye_x,
  input  wire  signed [COORD_BITS-1:0] in_eye_y,
  input  wire  signed [COORD_BITS-1:0] in_target_x,
  input  wire  signed [COORD_BITS-1:0] in_target_y,
  output logic                        out_valid,
  output logic signed [14:0]          out_aim_yaw,
  output logic        [14:0]          out_fov_angle
);

  // Offset width, normalized magnitude width, CORDIC datapath width
  localparam int DW = COORD_BITS + 1;
  localparam int NW = (DW > vaf_pkg::NORM_BIT + 1) ? DW : vaf_pkg::NORM_BIT + 1;
  localparam int XW = NW + 3;
  localparam int ZW = vaf_pkg::ZW;

  localparam logic signed [ZW-1:0] Z_HALF =
    ZW'(vaf_pkg::DEG64_HALF) <<< vaf_pkg::ANG_FRAC;

  // Always ready: the pipeline advances every cycle
  assign busy = 1'b0;

  // Stage 0: register the command and form the offsets
  logic                 v0_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [14:0]   yaw0_r;
  logic signed [13:0]   pitch0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start & ~busy;
    end
    dx_r     <= DW'(in_target_x) - DW'(in_eye_x);
    dy_r     <= DW'(in_target_y) - DW'(in_eye_y);
    yaw0_r   <= in_view_yaw;
    pitch0_r <= in_view_pitch;
  end

  // Stage 1: magnitudes, axis cases, half plane
  logic [DW-1:0]      mx, my;
  logic               dx_zero, dy_zero, dx_neg, dy_neg;
  vaf_pkg::sideband_t sb1_nxt, sb1_r;
  logic [NW-1:0]      ax_r, ay_r;

  always_comb begin
    dx_zero = (dx_r == '0);
    dy_zero = (dy_r == '0);
    dx_neg  = dx_r[DW-1];
    dy_neg  = dy_r[DW-1];
    mx      = dx_neg ? DW'(-dx_r) : DW'(dx_r);
    my      = dy_neg ? DW'(-dy_r) : DW'(dy_r);

    sb1_nxt.vld   = v0_r;
    sb1_nxt.spec  = dx_zero | dy_zero;
    sb1_nxt.flip  = dx_neg;
    sb1_nxt.ypos  = ~dy_neg & ~dy_zero;
    sb1_nxt.yneg  = dy_neg ^ dx_neg;
    sb1_nxt.yaw   = yaw0_r;
    sb1_nxt.pitch = pitch0_r;
    if (dy_zero) begin
      sb1_nxt.spec_aim = dx_neg ? 15'(vaf_pkg::DEG64_HALF) : '0;
    end else if (dy_neg) begin
      sb1_nxt.spec_aim = -15'(vaf_pkg::DEG64_QUARTER);
    end else begin
      sb1_nxt.spec_aim = 15'(vaf_pkg::DEG64_QUARTER);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb1_r.vld <= 1'b0;
    end else begin
      sb1_r <= sb1_nxt;
    end
    ax_r <= NW'(mx);
    ay_r <= NW'(my);
  end

  // Normalizer: shift steps of 32, 16, 8, 4, 2, 1
  logic [NW-1:0]      na [vaf_pkg::NORM_STEPS+1];
  logic [NW-1:0]      nb [vaf_pkg::NORM_STEPS+1];
  vaf_pkg::sideband_t nsb [vaf_pkg::NORM_STEPS+1];

  assign na[0]  = ax_r;
  assign nb[0]  = ay_r;
  assign nsb[0] = sb1_r;

  for (genvar j = 0; j < vaf_pkg::NORM_STEPS; j++) begin : g_norm
    vaf_norm_step #(
      .W (NW),
      .K (32 >> j)
    ) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .a_in   (na[j]),
      .b_in   (nb[j]),
      .sb_in  (nsb[j]),
      .a_out  (na[j+1]),
      .b_out  (nb[j+1]),
      .sb_out (nsb[j+1])
    );
  end

  // CORDIC setup: sign of y and starting angle for the left half plane
  logic signed [XW-1:0] xi_nxt, yi_nxt, ymag;
  logic signed [ZW-1:0] zi_nxt;
  logic signed [XW-1:0] xi_r, yi_r;
  logic signed [ZW-1:0] zi_r;
  vaf_pkg::sideband_t   sbi_r;

  always_comb begin
    xi_nxt = $signed({{(XW-NW){1'b0}}, na[vaf_pkg::NORM_STEPS]});
    ymag   = $signed({{(XW-NW){1'b0}}, nb[vaf_pkg::NORM_STEPS]});
    yi_nxt = nsb[vaf_pkg::NORM_STEPS].yneg ? -ymag : ymag;
    if (!nsb[vaf_pkg::NORM_STEPS].flip) begin
      zi_nxt = '0;
    end else if (nsb[vaf_pkg::NORM_STEPS].ypos) begin
      zi_nxt = Z_HALF;
    end else begin
      zi_nxt = -Z_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbi_r.vld <= 1'b0;
    end else begin
      sbi_r <= nsb[vaf_pkg::NORM_STEPS];
    end
    xi_r <= xi_nxt;
    yi_r <= yi_nxt;
    zi_r <= zi_nxt;
  end

  // CORDIC micro-rotations, one per stage
  logic signed [XW-1:0] cx  [CORDIC_STAGES+1];
  logic signed [XW-1:0] cy  [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz  [CORDIC_STAGES+1];
  vaf_pkg::sideband_t   csb [CORDIC_STAGES+1];

  assign cx[0]  = xi_r;
  assign cy[0]  = yi_r;
  assign cz[0]  = zi_r;
  assign csb[0] = sbi_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    vaf_cordic_stage #(
      .XW (XW),
      .I  (i)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .x_in   (cx[i]),
      .y_in   (cy[i]),
      .z_in   (cz[i]),
      .sb_in  (csb[i]),
      .x_out  (cx[i+1]),
      .y_out  (cy[i+1]),
      .z_out  (cz[i+1]),
      .sb_out (csb[i+1])
    );
  end

  // Round, wrap, compare and drive the result ports
  vaf_fov_calc u_fov (
    .clk           (clk),
    .rst_n         (rst_n),
    .z_in          (cz[CORDIC_STAGES]),
    .sb_in         (csb[CORDIC_STAGES]),
    .out_valid     (out_valid),
    .out_aim_yaw   (out_aim_yaw),
    .out_fov_angle (out_fov_angle)
  );

endmodule

`default_nettype wire

[test/aim_fov_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aim_fov_checker: predicts and checks aim yaw and field-of-view results
// Watches the command and result channels of the view angle block. On each
// command transfer it computes the aim yaw by CORDIC vectoring and the field
// of view angle, queues them, and compares each result transfer against the
// oldest queued prediction.
// ----------------------------------------------------------------------------
module aim_fov_checker #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_BITS    = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  input  wire                          busy,
  input  wire  signed [13:0]           in_view_pitch,
  input  wire  signed [14:0]           in_view_yaw,
  input  wire  signed [COORD_BITS-1:0] in_eye_x,
  input  wire  signed [COORD_BITS-1:0] in_eye_y,
  input  wire  signed [COORD_BITS-1:0] in_target_x,
  input  wire  signed [COORD_BITS-1:0] in_target_y,
  input  wire                          out_valid,
  input  wire  signed [14:0]           out_aim_yaw,
  input  wire         [14:0]           out_fov_angle,
  output int                           fail_count,
  output int                           aims_pending
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [14:0] aim_yaw;
    logic        [14:0] fov_angle;
  } aim_fov_t;

  aim_fov_t aims_due[$];
  int       mismatch_count;

  // Yaw toward (dx, dy) in 1/64 degree, CORDIC vectoring on a 2^-22 degree
  // accumulator.
  function automatic int aim_toward(input longint dx, input longint dy);
    longint ax, ay, x, y, z, xs, ys, ang;
    bit     flip, yneg;
    if (dy == 0) begin
      return (dx < 0) ? vaf_pkg::DEG64_HALF : 0;
    end
    if (dx == 0) begin
      return (dy > 0) ? vaf_pkg::DEG64_QUARTER : -vaf_pkg::DEG64_QUARTER;
    end
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    while (((ax | ay) >> vaf_pkg::NORM_BIT) == 0) begin
      ax = ax << 1;
      ay = ay << 1;
    end
    flip = (dx < 0);
    yneg = (dy < 0) != flip;
    x = ax;
    y = yneg ? -ay : ay;
    z = 0;
    if (flip) begin
      z = (dy > 0) ? (longint'(vaf_pkg::DEG64_HALF) <<< vaf_pkg::ANG_FRAC)
                   : -(longint'(vaf_pkg::DEG64_HALF) <<< vaf_pkg::ANG_FRAC);
    end
    for (int i = 0; i < CORDIC_STAGES && i < vaf_pkg::ATAN_DEPTH; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(vaf_pkg::ATAN_TAB[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(vaf_pkg::ATAN_TAB[i]);
      end
    end
    ang = (z + (longint'(1) <<< (vaf_pkg::ANG_FRAC - 1))) >>> vaf_pkg::ANG_FRAC;
    if (ang > vaf_pkg::DEG64_HALF) ang = ang - vaf_pkg::DEG64_FULL;
    if (ang < -vaf_pkg::DEG64_HALF) ang = ang + vaf_pkg::DEG64_FULL;
    return int'(ang);
  endfunction

  // Larger of the pole-wrapped yaw gap and the absolute pitch.
  function automatic int fov_between(input int pitch, input int yaw, input int aim);
    int dyaw, dpitch;
    if (yaw < -vaf_pkg::DEG64_QUARTER && aim > vaf_pkg::DEG64_QUARTER) begin
      dyaw = yaw + vaf_pkg::DEG64_FULL - aim;
    end else if (yaw > vaf_pkg::DEG64_QUARTER && aim < -vaf_pkg::DEG64_QUARTER) begin
      dyaw = aim + vaf_pkg::DEG64_FULL - yaw;
    end else begin
      dyaw = (yaw > aim) ? yaw - aim : aim - yaw;
    end
    if (dyaw < 0) dyaw = 0;
    dpitch = (pitch < 0) ? -pitch : pitch;
    return (dyaw > dpitch) ? dyaw : dpitch;
  endfunction

  initial begin
    fail_count     = 0;
    aims_pending   = 0;
    mismatch_count = 0;
  end

  always @(posedge clk) begin
    aim_fov_t predicted, seen;
    int       aim;
    if (rst_n && start && !busy) begin
      aim = aim_toward(longint'(in_target_x) - longint'(in_eye_x),
                       longint'(in_target_y) - longint'(in_eye_y));
      predicted.aim_yaw   = aim[14:0];
      predicted.fov_angle = 15'(fov_between(int'(in_view_pitch), int'(in_view_yaw), aim));
      aims_due.push_back(predicted);
    end
    if (rst_n && out_valid) begin
      seen.aim_yaw   = out_aim_yaw;
      seen.fov_angle = out_fov_angle;
      if (aims_due.size() == 0) begin
        fail_count = fail_count + 1;
        if (mismatch_count < REPORT_LIMIT) begin
          $display("%0t: result with nothing expected: aim_yaw %0d fov_angle %0d",
                   $realtime, seen.aim_yaw, seen.fov_angle);
        end
        mismatch_count = mismatch_count + 1;
      end else begin
        predicted = aims_due.pop_front();
        if (seen.aim_yaw != predicted.aim_yaw || seen.fov_angle != predicted.fov_angle) begin
          fail_count = fail_count + 1;
          if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: mismatch: aim_yaw exp %0d got %0d, fov_angle exp %0d got %0d",
                     $realtime, predicted.aim_yaw, seen.aim_yaw,
                     predicted.fov_angle, seen.fov_angle);
          end
          mismatch_count = mismatch_count + 1;
        end
      end
    end
    aims_pending = aims_due.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for view_angle_fov_to_target
// Drives target queries (directed corner cases, then randomized traffic with
// random gaps and gap-free bursts), lets the checker predict and compare
// every result, guards the run with an idle watchdog, and gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int CORDIC_STAGES = 16;
  localparam int COORD_BITS    = 32;
  // Pipeline depth of the block, used for the drain at the end of the run
  localparam int LATENCY       = CORDIC_STAGES + 11;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int IDLE_LIMIT    = 2000;

  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;

  typedef struct {
    int                          pitch;
    int                          yaw;
    logic signed [COORD_BITS-1:0] eye_x;
    logic signed [COORD_BITS-1:0] eye_y;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
  } target_query_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic signed [13:0]           in_view_pitch;
  logic signed [14:0]           in_view_yaw;
  logic signed [COORD_BITS-1:0] in_eye_x;
  logic signed [COORD_BITS-1:0] in_eye_y;
  logic signed [COORD_BITS-1:0] in_target_x;
  logic signed [COORD_BITS-1:0] in_target_y;
  logic                         out_valid;
  logic signed [14:0]           out_aim_yaw;
  logic        [14:0]           out_fov_angle;

  int fail_count;
  int aims_pending;
  int idle_cycles;
  bit burst_mode;

  view_angle_fov_to_target #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .COORD_BITS    (COORD_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_view_pitch (in_view_pitch),
    .in_view_yaw   (in_view_yaw),
    .in_eye_x      (in_eye_x),
    .in_eye_y      (in_eye_y),
    .in_target_x   (in_target_x),
    .in_target_y   (in_target_y),
    .out_valid     (out_valid),
    .out_aim_yaw   (out_aim_yaw),
    .out_fov_angle (out_fov_angle)
  );

  aim_fov_checker #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .COORD_BITS    (COORD_BITS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_view_pitch (in_view_pitch),
    .in_view_yaw   (in_view_yaw),
    .in_eye_x      (in_eye_x),
    .in_eye_y      (in_eye_y),
    .in_target_x   (in_target_x),
    .in_target_y   (in_target_y),
    .out_valid     (out_valid),
    .out_aim_yaw   (out_aim_yaw),
    .out_fov_angle (out_fov_angle),
    .fail_count    (fail_count),
    .aims_pending  (aims_pending)
  );

  // 20 ns clock: 10 ns high, 10 ns low
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Watchdog: count cycles with no transfer on either channel; a stuck
  // pipeline or a lost result ends the run here.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Gap before the next command: none inside a burst, else a random one.
  function automatic int draw_gap();
    return burst_mode ? 0 : int'($urandom_range(0, 9));
  endfunction

  // Hold start low for the gap, present the query at the falling edge, then
  // wait for the transfer (start high, busy low at a rising edge). When the
  // gap is zero start simply stays high into the next command.
  task automatic send_query(input target_query_t q, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_view_pitch = 14'(q.pitch);
    in_view_yaw   = 15'(q.yaw);
    in_eye_x      = q.eye_x;
    in_eye_y      = q.eye_y;
    in_target_x   = q.target_x;
    in_target_y   = q.target_y;
    start         = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
  endtask

  task automatic send_fixed(input int pitch, input int yaw,
                            input logic signed [31:0] ex, input logic signed [31:0] ey,
                            input logic signed [31:0] tx, input logic signed [31:0] ty);
    target_query_t q;
    q.pitch    = pitch;
    q.yaw      = yaw;
    q.eye_x    = ex;
    q.eye_y    = ey;
    q.target_x = tx;
    q.target_y = ty;
    send_query(q, draw_gap());
  endtask

  // Random query. Most view angles stay in their nominal range, with a share
  // pushed toward the poles and a few anywhere in the field width. Geometry
  // mixes wide random offsets, small offsets, axis cases, extremes and
  // vectors close to the negative x axis where the 180 degree wrap lives.
  function automatic target_query_t random_query();
    target_query_t q;
    int            kind, shift;
    logic signed [31:0] corner [5];
    corner = '{COORD_MIN, COORD_MAX, 32'sd0, -32'sd1, 32'sd1};
    kind = $urandom_range(0, 99);
    if (kind < 85) q.pitch = $urandom_range(0, 2 * 5696) - 5696;
    else           q.pitch = int'($urandom_range(0, 16383)) - 8192;
    kind = $urandom_range(0, 99);
    if (kind < 60)      q.yaw = $urandom_range(0, 2 * 11520) - 11520;
    else if (kind < 75) q.yaw = $urandom_range(5761, 11520);
    else if (kind < 90) q.yaw = -int'($urandom_range(5761, 11520));
    else                q.yaw = int'($urandom_range(0, 32767)) - 16384;

    q.eye_x    = $urandom;
    q.eye_y    = $urandom;
    q.target_x = $urandom;
    q.target_y = $urandom;
    kind = $urandom_range(0, 9);
    case (kind)
      4, 5: begin
        shift = $urandom_range(0, 24);
        q.target_x = q.eye_x + (($urandom & ((32'd1 << shift) - 1)) - (32'd1 << (shift - 1)));
        q.target_y = q.eye_y + (($urandom & ((32'd1 << shift) - 1)) - (32'd1 << (shift - 1)));
      end
      6: begin
        if ($urandom_range(0, 1)) q.target_x = q.eye_x;
        else                      q.target_y = q.eye_y;
      end
      7: begin
        q.target_x = q.eye_x + $urandom_range(0, 6) - 3;
        q.target_y = q.eye_y + $urandom_range(0, 6) - 3;
      end
      8: begin
        q.eye_x    = corner[$urandom_range(0, 4)];
        q.eye_y    = corner[$urandom_range(0, 4)];
        q.target_x = corner[$urandom_range(0, 4)];
        q.target_y = corner[$urandom_range(0, 4)];
      end
      9: begin
        // far left, nearly on the axis: aim close to plus or minus 180
        q.target_x = q.eye_x - $urandom_range(1, 32'h3fff_ffff);
        q.target_y = q.eye_y + $urandom_range(0, 64) - 32;
      end
      default: begin
      end
    endcase
    return q;
  endfunction

  initial begin
    // Known values on every input from time zero
    rst_n         = 1'b0;
    start         = 1'b0;
    in_view_pitch = '0;
    in_view_yaw   = '0;
    in_eye_x      = '0;
    in_eye_y      = '0;
    in_target_x   = '0;
    in_target_y   = '0;
    burst_mode    = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed corners: zero offset, each axis direction, extreme offsets,
    // both left-half-plane signs, the 180 degree wrap, the opposing-pole
    // rule, out-of-range view angles and saturation of the yaw gap.
    send_fixed(    0,      0,         0,         0,         0,         0);
    send_fixed( 5696, -11520,       100,       200,       100,       200);
    send_fixed(-5696,  11520,         0,         0,     65536,         0);
    send_fixed(    0,      0,         0,         0,    -65536,         0);
    send_fixed(    0,      0,         0,         0,         0,     65536);
    send_fixed(    0,      0,         0,         0,         0,        -1);
    send_fixed(    0,      0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_fixed(    0,      0, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    send_fixed(    0,      0, COORD_MAX,         0, COORD_MIN,         1);
    send_fixed(    0,      0, COORD_MAX,         1, COORD_MIN,         0);
    send_fixed(    0,      0,         0,         0,         1,         1);
    send_fixed(    0,      0,         0,         0,        -1,         1);
    send_fixed(    0,      0,         0,         0,        -1,        -1);
    send_fixed(    0,      0,         0,         0,         1,        -1);
    send_fixed(    0, -11520,         0,         0,    -65536,     65536);
    send_fixed(    0,  11520,         0,         0,    -65536,    -65536);
    send_fixed(    0, -16384,         0,         0,        -5,         0);
    send_fixed(    0,  16383,         0,         1,      -100,         0);
    send_fixed(-8192,      0,         0,         0,      1000,       999);
    send_fixed( 8191,     -1, COORD_MIN,         0, COORD_MAX,        -7);
    send_fixed(    0,   5761,         0,         0,        -1,     -1000);
    send_fixed(   64,  -5761,         0,         0,        -1,      1000);

    // Random traffic; every 100 commands pick either a gap-free burst or
    // random gaps so that idle cycles land on every pipeline stage.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_query(random_query(), draw_gap());
    end
    start = 1'b0;

    // Drain: wait for every predicted result, then watch a bit longer for
    // stray results.
    while (aims_pending != 0) @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);

    if (fail_count == 0 && aims_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[view_angle_fov_to_target.f]
rtl/vaf_pkg.sv
rtl/vaf_norm_step.sv
rtl/vaf_cordic_stage.sv
rtl/vaf_fov_calc.sv
rtl/view_angle_fov_to_target.sv
test/aim_fov_checker.sv
test/tb.sv
